// ===== hw/rtl/saabb_pkg.sv =====
// Package with the shared default coordinate width for the segment versus box slab test.
package saabb_pkg;
    localparam int COORD_WIDTH_DEF = 32;
endpackage

// ===== hw/rtl/segment_aabb_slab_test_top.sv =====
// Top level of the pipelined segment versus axis-aligned box slab test.
// An item accepted with start has its result on done and hit after the hit reduction
// stage. Throughput: one item in every cycle.
// Stages: plane setup, plane order compare, near and far select, bound and cross
// compares, hit reduction. Reset clears the valid pipeline; busy is always low.
module segment_aabb_slab_test_top #(
    parameter int COORD_WIDTH = saabb_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] origin_x,
    input  logic signed [COORD_WIDTH-1:0] origin_y,
    input  logic signed [COORD_WIDTH-1:0] origin_z,
    input  logic signed [COORD_WIDTH-1:0] dir_x,
    input  logic signed [COORD_WIDTH-1:0] dir_y,
    input  logic signed [COORD_WIDTH-1:0] dir_z,
    input  logic signed [COORD_WIDTH-1:0] box_min_x,
    input  logic signed [COORD_WIDTH-1:0] box_min_y,
    input  logic signed [COORD_WIDTH-1:0] box_min_z,
    input  logic signed [COORD_WIDTH-1:0] box_max_x,
    input  logic signed [COORD_WIDTH-1:0] box_max_y,
    input  logic signed [COORD_WIDTH-1:0] box_max_z,
    output logic                          done,
    output logic                          hit
);
    localparam int CW = COORD_WIDTH;
    localparam int NS = 5;

    logic [CW:0] ta_mag [3];
    logic [CW:0] tb_mag [3];
    logic        ta_neg [3];
    logic        tb_neg [3];
    logic [CW:0] den    [3];
    logic        par    [3];
    logic        par_ok [3];

    logic signed [CW-1:0] ov [3];
    logic signed [CW-1:0] dv [3];
    logic signed [CW-1:0] mnv [3];
    logic signed [CW-1:0] mxv [3];

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;

    // Ordered planes of every axis.
    logic [CW:0] s_amag_reg [3];
    logic [CW:0] s_bmag_reg [3];
    logic        s_aneg_reg [3];
    logic        s_bneg_reg [3];
    logic [CW:0] s_den_reg  [3];
    logic        s_par_reg  [3];
    logic        s_ok_reg   [3];

    logic          hit_reg;

    assign ov  = '{origin_x, origin_y, origin_z};
    assign dv  = '{dir_x, dir_y, dir_z};
    assign mnv = '{box_min_x, box_min_y, box_min_z};
    assign mxv = '{box_max_x, box_max_y, box_max_z};

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        saabb_axis #(.CW(CW)) u_axis (
            .clk(clk), .o(ov[a]), .d(dv[a]), .bmin(mnv[a]), .bmax(mxv[a]),
            .ta_mag_reg(ta_mag[a]), .tb_mag_reg(tb_mag[a]),
            .ta_neg_reg(ta_neg[a]), .tb_neg_reg(tb_neg[a]),
            .den_reg(den[a]), .par_reg(par[a]), .par_ok_reg(par_ok[a])
        );
    end

    // Per-axis order: a registered compare, then a registered near and far select.
    logic          ord_gt [3];
    logic [CW:0]   c1_amag_reg [3];
    logic [CW:0]   c1_bmag_reg [3];
    logic          c1_aneg_reg [3];
    logic          c1_bneg_reg [3];
    logic [CW:0]   c1_den_reg  [3];
    logic          c1_par_reg  [3];
    logic          c1_ok_reg   [3];

    for (genvar a = 0; a < 3; a++)
    begin : g_ord
        saabb_cmp #(.CW(CW)) u_ord (
            .clk(clk),
            .xneg(ta_neg[a]), .xmag(ta_mag[a]), .xden(den[a]),
            .yneg(tb_neg[a]), .ymag(tb_mag[a]), .yden(den[a]),
            .gt_reg(ord_gt[a])
        );
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            c1_amag_reg[a] <= ta_mag[a];
            c1_bmag_reg[a] <= tb_mag[a];
            c1_aneg_reg[a] <= ta_neg[a];
            c1_bneg_reg[a] <= tb_neg[a];
            c1_den_reg[a]  <= den[a];
            c1_par_reg[a]  <= par[a];
            c1_ok_reg[a]   <= par_ok[a];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            s_amag_reg[a] <= ord_gt[a] ? c1_bmag_reg[a] : c1_amag_reg[a];
            s_aneg_reg[a] <= ord_gt[a] ? c1_bneg_reg[a] : c1_aneg_reg[a];
            s_bmag_reg[a] <= ord_gt[a] ? c1_amag_reg[a] : c1_bmag_reg[a];
            s_bneg_reg[a] <= ord_gt[a] ? c1_aneg_reg[a] : c1_bneg_reg[a];
            s_den_reg[a]  <= c1_den_reg[a];
            s_par_reg[a]  <= c1_par_reg[a];
            s_ok_reg[a]   <= c1_ok_reg[a];
        end
    end

    // Per-axis near and far against [0,1]: near above one and far below zero
    // tests, then a pairwise cross check of every near against every far.
    logic          nz_gt [3];
    logic          fo_gt [3];
    logic [CW:0]   one_v;
    assign one_v = {{CW{1'b0}}, 1'b1};

    for (genvar a = 0; a < 3; a++)
    begin : g_bnd
        saabb_cmp #(.CW(CW)) u_nz (
            .clk(clk),
            .xneg(s_aneg_reg[a]), .xmag(s_amag_reg[a]), .xden(s_den_reg[a]),
            .yneg(1'b0), .ymag(one_v), .yden(one_v),
            .gt_reg(nz_gt[a])
        );
        saabb_cmp #(.CW(CW)) u_fo (
            .clk(clk),
            .xneg(1'b0), .xmag({(CW+1){1'b0}}), .xden(one_v),
            .yneg(s_bneg_reg[a]), .ymag(s_bmag_reg[a]), .yden(s_den_reg[a]),
            .gt_reg(fo_gt[a])
        );
    end

    // Cross compares near[i] > far[j] for every pair of axes.
    logic xg [3][3];
    for (genvar i = 0; i < 3; i++)
    begin : g_xi
        for (genvar j = 0; j < 3; j++)
        begin : g_xj
            saabb_cmp #(.CW(CW)) u_x (
                .clk(clk),
                .xneg(s_aneg_reg[i]), .xmag(s_amag_reg[i]), .xden(s_den_reg[i]),
                .yneg(s_bneg_reg[j]), .ymag(s_bmag_reg[j]), .yden(s_den_reg[j]),
                .gt_reg(xg[i][j])
            );
        end
    end

    logic par2_reg [3];
    logic ok2_reg  [3];
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            par2_reg[a] <= s_par_reg[a];
            ok2_reg[a]  <= s_ok_reg[a];
        end
    end

    // Final reduction misses: parallel out of slab, near > 1, far < 0, near > far.
    logic miss_c;
    always_comb
    begin
        miss_c = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            if (par2_reg[a])
            begin
                if (!ok2_reg[a])
                    miss_c = 1'b1;
            end
            else
            begin
                if (nz_gt[a] || fo_gt[a])
                    miss_c = 1'b1;
            end
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (!par2_reg[i] && !par2_reg[j] && xg[i][j])
                    miss_c = 1'b1;
    end

    always_ff @(posedge clk)
        hit_reg <= !miss_c;

    always_comb
        vld_next = {vld_reg[NS-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign busy = 1'b0;
    assign done = vld_reg[NS-1];
    assign hit  = hit_reg;
endmodule

// ===== hw/rtl/saabb_axis.sv =====
// Per-axis slab setup: plane parameters as exact fractions and parallel-axis flags.
module saabb_axis #(
    parameter int CW = saabb_pkg::COORD_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic signed [CW-1:0] o,
    input  logic signed [CW-1:0] d,
    input  logic signed [CW-1:0] bmin,
    input  logic signed [CW-1:0] bmax,
    output logic [CW:0]          ta_mag_reg,
    output logic [CW:0]          tb_mag_reg,
    output logic                 ta_neg_reg,
    output logic                 tb_neg_reg,
    output logic [CW:0]          den_reg,
    output logic                 par_reg,
    output logic                 par_ok_reg
);
    logic signed [CW:0] da;
    logic signed [CW:0] db;
    logic signed [CW:0] dx;
    logic               dneg;

    always_comb
    begin
        da   = {bmin[CW-1], bmin} - {o[CW-1], o};
        db   = {bmax[CW-1], bmax} - {o[CW-1], o};
        dx   = {d[CW-1], d};
        dneg = d[CW-1];
    end

    always_ff @(posedge clk)
    begin
        ta_mag_reg <= da[CW] ? (~da + 1'b1) : da;
        tb_mag_reg <= db[CW] ? (~db + 1'b1) : db;
        ta_neg_reg <= da[CW] ^ dneg;
        tb_neg_reg <= db[CW] ^ dneg;
        den_reg    <= dneg ? (~dx + 1'b1) : dx;
        par_reg    <= (d == '0);
        par_ok_reg <= (o >= bmin) && (o <= bmax);
    end
endmodule

// ===== hw/rtl/saabb_cmp.sv =====
// Registered exact comparison of two signed fractions: gt is x greater than y.
module saabb_cmp #(
    parameter int CW = saabb_pkg::COORD_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          xneg,
    input  logic [CW:0]   xmag,
    input  logic [CW:0]   xden,
    input  logic          yneg,
    input  logic [CW:0]   ymag,
    input  logic [CW:0]   yden,
    output logic          gt_reg
);
    logic sx;
    logic sy;
    logic [2*CW+1:0] p1;
    logic [2*CW+1:0] p2;

    always_comb
    begin
        sx = xneg && (xmag != '0);
        sy = yneg && (ymag != '0);
        p1 = xmag * yden;
        p2 = ymag * xden;
    end

    always_ff @(posedge clk)
    begin
        if (sx != sy)
            gt_reg <= sy;
        else
            gt_reg <= sx ? (p1 < p2) : (p1 > p2);
    end
endmodule
